[design/bqd_pkg.sv]
// Shared types and constants for the cascaded biquad filter.
// No dependencies; imported by every module of the block except bqd_vram.
`default_nettype none

package bqd_pkg;

    localparam int WORD_W        = 32;
    localparam int COEFS_PER_SEC = 5;
    localparam int FRAC_SHIFT    = 2;
    localparam int CIDX_W        = 3;
    localparam int CSEC_W        = 3;
    localparam int NSEC_W        = 4;
    localparam int TDATA_W       = 72;

    // coefficient slots inside one section row
    localparam logic [CIDX_W-1:0] CI_A1 = 3'd0;
    localparam logic [CIDX_W-1:0] CI_A2 = 3'd1;
    localparam logic [CIDX_W-1:0] CI_B0 = 3'd2;
    localparam logic [CIDX_W-1:0] CI_B1 = 3'd3;
    localparam logic [CIDX_W-1:0] CI_B2 = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MUL_A1,
        ST_MUL_A2,
        ST_MUL_B1,
        ST_MUL_B2,
        ST_MUL_B0,
        ST_ACC_B0,
        ST_DONE
    } seq_state_t;

    typedef enum logic [1:0] {
        OPB_DLY,
        OPB_W1,
        OPB_W2,
        OPB_W
    } opb_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_INIT,
        ACC_SUB,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef struct packed {
        opb_sel_t opb_sel;
        acc_op_t  acc_op;
        logic     cap_w1;
        logic     cap_w2;
        logic     cap_w;
        logic     dly_we;
        logic     dly_wsel_w;   // 1: write new w, 0: write old w1
    } mac_ctrl_t;

endpackage

`default_nettype wire

[design/cascaded_biquad_iir_filter_unit.sv]
// Cascaded biquad IIR filter: coefficient beats are written to the table while idle.
// Sample beat: each active section steps through fetch, five products and a final
// add; the next sample is accepted only after the result is loaded into the output
// register, as the single shared multiplier does five products per section.
// Reset: coefficients and delay state read as zero, section count is 1.
`default_nettype none

module cascaded_biquad_iir_filter_unit #(
    parameter int MAX_SECTIONS = 8
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [3:0]                cfg_wdata,     // num_sections
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // coef_section[2:0], coef_index[5:3], coef_value[37:6], sample_in[69:38]
    input  wire logic [bqd_pkg::TDATA_W-1:0] s_axis_tdata,
    input  wire logic                      s_axis_tuser,  // func
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output logic [31:0]                    m_axis_tdata   // sample_out
);

    import bqd_pkg::*;

    localparam int CA_W = $clog2(5 * MAX_SECTIONS);
    localparam int DA_W = $clog2(2 * MAX_SECTIONS);

    logic [CSEC_W-1:0] coef_section;
    logic [CIDX_W-1:0] coef_index;
    logic [WORD_W-1:0] coef_value;
    logic [WORD_W-1:0] sample_in;
    logic              in_beat;
    logic              coef_we;
    logic [CA_W-1:0]   coef_waddr;
    logic [CA_W-1:0]   coef_raddr;
    logic [WORD_W-1:0] coef_rdata;
    logic [DA_W-1:0]   dly_addr;
    logic [WORD_W-1:0] dly_rdata;
    logic [WORD_W-1:0] dly_wdata;
    logic [WORD_W-1:0] acc;
    mac_ctrl_t         ctrl;
    logic              idle;
    logic              out_load;
    logic              out_free;
    logic [NSEC_W-1:0] num_sec_reg;
    logic              out_vld_reg;
    logic [WORD_W-1:0] out_reg;

    assign coef_section = s_axis_tdata[2:0];
    assign coef_index   = s_axis_tdata[5:3];
    assign coef_value   = s_axis_tdata[37:6];
    assign sample_in    = s_axis_tdata[69:38];

    assign s_axis_tready = idle;
    assign in_beat       = s_axis_tvalid && idle;

    // writes to a slot past b2 or a section past the table are dropped
    assign coef_we = in_beat && !s_axis_tuser
                     && (coef_index <= CI_B2)
                     && (32'(coef_section) < MAX_SECTIONS);
    assign coef_waddr = CA_W'(CA_W'(coef_section) * CA_W'(COEFS_PER_SEC)
                              + CA_W'(coef_index));

    assign out_free = !out_vld_reg || m_axis_tready;

    bqd_vram #(
        .DEPTH (COEFS_PER_SEC * MAX_SECTIONS),
        .WIDTH (WORD_W)
    ) u_coef_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_value),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    bqd_vram #(
        .DEPTH (2 * MAX_SECTIONS),
        .WIDTH (WORD_W)
    ) u_dly_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (ctrl.dly_we),
        .waddr (dly_addr),
        .wdata (dly_wdata),
        .raddr (dly_addr),
        .rdata (dly_rdata)
    );

    bqd_seq #(
        .MAX_SECTIONS (MAX_SECTIONS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (in_beat && s_axis_tuser),
        .num_sections (num_sec_reg),
        .out_free     (out_free),
        .idle         (idle),
        .out_load     (out_load),
        .ctrl         (ctrl),
        .coef_raddr   (coef_raddr),
        .dly_addr     (dly_addr)
    );

    bqd_mac u_mac (
        .clk        (clk),
        .ctrl       (ctrl),
        .sample_in  (sample_in),
        .coef_rdata (coef_rdata),
        .dly_rdata  (dly_rdata),
        .dly_wdata  (dly_wdata),
        .acc        (acc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_sec_reg <= NSEC_W'(1);
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                num_sec_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= acc;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_reg;

endmodule

`default_nettype wire

[design/bqd_vram.sv]
// Single-port-write / single-read memory with per-entry valid bits.
// Entries never written read as zero. Uses no package.
`default_nettype none

module bqd_vram #(
    parameter int DEPTH = 40,
    parameter int WIDTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [WIDTH-1:0] rdata_reg;
    logic             rvld_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            rvld_reg <= vld_reg[raddr];
        end
    end

    assign rdata = rvld_reg ? rdata_reg : '0;

endmodule

`default_nettype wire

[design/bqd_mac.sv]
// Shared multiply-accumulate datapath: one 32x32 signed multiplier
// (upper half registered), one add/sub accumulator, delay holding regs.
// Depends on bqd_pkg.
`default_nettype none

module bqd_mac (
    input  wire logic                  clk,
    input  wire bqd_pkg::mac_ctrl_t    ctrl,
    input  wire logic [31:0]           sample_in,
    input  wire logic [31:0]           coef_rdata,
    input  wire logic [31:0]           dly_rdata,
    output logic      [31:0]           dly_wdata,
    output logic      [31:0]           acc
);

    import bqd_pkg::*;

    logic signed [WORD_W-1:0]   op_a;
    logic signed [WORD_W-1:0]   op_b;
    logic signed [2*WORD_W-1:0] full_prod;
    logic [WORD_W-1:0]          prod_reg;
    logic [WORD_W-1:0]          acc_reg;
    logic [WORD_W-1:0]          acc_next;
    logic [WORD_W-1:0]          w1_reg;
    logic [WORD_W-1:0]          w2_reg;
    logic [WORD_W-1:0]          w_reg;

    always_comb
    begin
        op_a = $signed(coef_rdata);
        case (ctrl.opb_sel)
            OPB_DLY: op_b = $signed(dly_rdata);
            OPB_W1:  op_b = $signed(w1_reg);
            OPB_W2:  op_b = $signed(w2_reg);
            OPB_W:   op_b = $signed(w_reg);
            default: op_b = $signed(dly_rdata);
        endcase
    end

    assign full_prod = op_a * op_b;

    always_comb
    begin
        case (ctrl.acc_op)
            ACC_INIT: acc_next = sample_in;
            ACC_SUB:  acc_next = acc_reg - prod_reg;
            ACC_LOAD: acc_next = prod_reg;
            ACC_ADD:  acc_next = acc_reg + prod_reg;
            default:  acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= full_prod[2*WORD_W-1:WORD_W];
        acc_reg  <= acc_next;
        if (ctrl.cap_w1)
        begin
            w1_reg <= dly_rdata;
        end
        if (ctrl.cap_w2)
        begin
            w2_reg <= dly_rdata;
        end
        // feedback sum, scaled back up by the fractional shift
        if (ctrl.cap_w)
        begin
            w_reg <= acc_reg << FRAC_SHIFT;
        end
    end

    assign dly_wdata = ctrl.dly_wsel_w ? w_reg : w1_reg;
    assign acc       = acc_reg;

endmodule

`default_nettype wire

[design/bqd_seq.sv]
// Sequencer: steps the shared MAC through five products per section
// and walks the active sections. Depends on bqd_pkg.
`default_nettype none

module bqd_seq #(
    parameter int MAX_SECTIONS = 8,
    localparam int SEC_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1,
    localparam int CA_W  = $clog2(5 * MAX_SECTIONS),
    localparam int DA_W  = $clog2(2 * MAX_SECTIONS)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [3:0]           num_sections,
    input  wire logic                 out_free,
    output logic                      idle,
    output logic                      out_load,
    output bqd_pkg::mac_ctrl_t        ctrl,
    output logic      [CA_W-1:0]      coef_raddr,
    output logic      [DA_W-1:0]      dly_addr
);

    import bqd_pkg::*;

    seq_state_t        state_reg;
    seq_state_t        state_next;
    logic [SEC_W-1:0]  sec_reg;
    logic [SEC_W-1:0]  sec_next;
    logic [SEC_W-1:0]  last_reg;
    logic [SEC_W-1:0]  last_next;
    logic [SEC_W-1:0]  last_in;
    logic [CIDX_W-1:0] cidx;
    logic              dly_odd;
    logic              at_last;

    assign at_last = (sec_reg == last_reg);

    // zero sections runs one, above the maximum runs all
    always_comb
    begin
        if (num_sections == '0)
        begin
            last_in = '0;
        end
        else if (32'(num_sections) > MAX_SECTIONS)
        begin
            last_in = SEC_W'(MAX_SECTIONS - 1);
        end
        else
        begin
            last_in = SEC_W'(num_sections - 4'd1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (start) state_next = ST_FETCH;
            ST_FETCH:  state_next = ST_MUL_A1;
            ST_MUL_A1: state_next = ST_MUL_A2;
            ST_MUL_A2: state_next = ST_MUL_B1;
            ST_MUL_B1: state_next = ST_MUL_B2;
            ST_MUL_B2: state_next = ST_MUL_B0;
            ST_MUL_B0: state_next = ST_ACC_B0;
            ST_ACC_B0: state_next = at_last ? ST_DONE : ST_FETCH;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        sec_next  = sec_reg;
        last_next = last_reg;
        if (state_reg == ST_IDLE && start)
        begin
            sec_next  = '0;
            last_next = last_in;
        end
        else if (state_reg == ST_ACC_B0 && !at_last)
        begin
            sec_next = sec_reg + 1'b1;
        end
    end

    always_comb
    begin
        idle         = 1'b0;
        out_load     = 1'b0;
        cidx         = CI_A1;
        dly_odd      = 1'b0;
        ctrl         = '0;
        ctrl.opb_sel = OPB_DLY;
        ctrl.acc_op  = ACC_HOLD;
        unique case (state_reg)
            ST_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    ctrl.acc_op = ACC_INIT;
                end
            end
            ST_FETCH:
            begin
                cidx = CI_A1;
            end
            ST_MUL_A1:
            begin
                cidx        = CI_A2;
                dly_odd     = 1'b1;
                ctrl.cap_w1 = 1'b1;
            end
            ST_MUL_A2:
            begin
                cidx        = CI_B1;
                ctrl.cap_w2 = 1'b1;
                ctrl.acc_op = ACC_SUB;
            end
            ST_MUL_B1:
            begin
                cidx         = CI_B2;
                ctrl.opb_sel = OPB_W1;
                ctrl.acc_op  = ACC_SUB;
            end
            ST_MUL_B2:
            begin
                cidx         = CI_B0;
                ctrl.opb_sel = OPB_W2;
                ctrl.acc_op  = ACC_LOAD;
                ctrl.cap_w   = 1'b1;
            end
            ST_MUL_B0:
            begin
                ctrl.opb_sel = OPB_W;
                ctrl.acc_op  = ACC_ADD;
                ctrl.dly_we  = 1'b1;
                dly_odd      = 1'b1;
            end
            ST_ACC_B0:
            begin
                ctrl.acc_op     = ACC_ADD;
                ctrl.dly_we     = 1'b1;
                ctrl.dly_wsel_w = 1'b1;
            end
            ST_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
                idle = 1'b0;
            end
        endcase
    end

    assign coef_raddr = CA_W'(CA_W'(sec_reg) * CA_W'(COEFS_PER_SEC) + CA_W'(cidx));
    assign dly_addr   = DA_W'({sec_reg, 1'b0}) | DA_W'(dly_odd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sec_reg   <= '0;
            last_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sec_reg   <= sec_next;
            last_reg  <= last_next;
        end
    end

endmodule

`default_nettype wire

[tb/bqd_cascade_checker.sv]
// Beat layout shared by the stimulus side and the scoreboard, plus the scoreboard
// itself: it follows section-count and coefficient writes, predicts every filtered
// sample and checks output beats in order. Depends on bqd_pkg.
package bqd_tb_pkg;

    localparam int MAX_SEC = 8;
    localparam int PAD_W   = bqd_pkg::TDATA_W - 2 * bqd_pkg::WORD_W
                             - bqd_pkg::CIDX_W - bqd_pkg::CSEC_W;

    typedef enum logic {
        FN_COEF   = 1'b0,
        FN_SAMPLE = 1'b1
    } func_t;

    typedef struct packed {
        logic [PAD_W-1:0]            pad;
        logic [bqd_pkg::WORD_W-1:0]  sample_in;
        logic [bqd_pkg::WORD_W-1:0]  coef_value;
        logic [bqd_pkg::CIDX_W-1:0]  coef_index;
        logic [bqd_pkg::CSEC_W-1:0]  coef_section;
    } beat_t;

endpackage

module bqd_cascade_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [bqd_pkg::NSEC_W-1:0]   cfg_wdata,
    input  wire logic                         s_tvalid,
    input  wire logic                         s_tready,
    input  wire logic [bqd_pkg::TDATA_W-1:0]  s_tdata,
    input  wire logic                         s_tuser,
    input  wire logic                         m_tvalid,
    input  wire logic                         m_tready,
    input  wire logic [31:0]                  m_tdata,
    output int                                errors,
    output int                                pending,
    output int                                checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import bqd_pkg::*;
    import bqd_tb_pkg::*;

    int                coef_tbl [MAX_SEC][COEFS_PER_SEC];
    int                w1_mem [MAX_SEC];
    int                w2_mem [MAX_SEC];
    logic [NSEC_W-1:0] sec_count;
    int                expected_out [$];
    int                err_count;
    int                shown;
    int                n_checked;

    // upper word of the full signed 64-bit product
    function automatic int mul_hi(input int a, input int b);
        longint prod;
        prod = longint'(a) * longint'(b);
        return int'(prod >>> 32);
    endfunction

    // runs one sample through the active sections, updating the delay pairs
    function automatic int filter_sample(input int x);
        int n;
        int w;
        int acc;
        n = (sec_count == 0) ? 1 : (sec_count > MAX_SEC) ? MAX_SEC : int'(sec_count);
        acc = x;
        for (int s = 0; s < n; s++)
        begin
            w = acc - mul_hi(coef_tbl[s][CI_A1], w1_mem[s])
                    - mul_hi(coef_tbl[s][CI_A2], w2_mem[s]);
            w = w << FRAC_SHIFT;
            acc = mul_hi(coef_tbl[s][CI_B0], w)
                + mul_hi(coef_tbl[s][CI_B1], w1_mem[s])
                + mul_hi(coef_tbl[s][CI_B2], w2_mem[s]);
            w2_mem[s] = w1_mem[s];
            w1_mem[s] = w;
        end
        return acc;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        beat_t beat;
        int    want;
        if (!rst_n)
        begin
            for (int s = 0; s < MAX_SEC; s++)
            begin
                for (int c = 0; c < COEFS_PER_SEC; c++)
                    coef_tbl[s][c] = 0;
                w1_mem[s] = 0;
                w2_mem[s] = 0;
            end
            sec_count = 1;
            expected_out.delete();
            err_count = 0;
            shown = 0;
            n_checked = 0;
        end
        else
        begin
            if (cfg_we)
                sec_count = cfg_wdata;

            if (m_tvalid && m_tready)
            begin
                if (expected_out.size() == 0)
                begin
                    err_count++;
                    if (shown < 10)
                    begin
                        shown++;
                        $display("%0t: output beat 0x%08h with no sample outstanding",
                                 $realtime, m_tdata);
                    end
                end
                else
                begin
                    want = expected_out.pop_front();
                    n_checked++;
                    if (m_tdata !== want)
                    begin
                        err_count++;
                        if (shown < 10)
                        begin
                            shown++;
                            $display("%0t: sample_out expected %0d (0x%08h), got %0d (0x%08h)",
                                     $realtime, want, want, $signed(m_tdata), m_tdata);
                        end
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                beat = beat_t'(s_tdata);
                if (s_tuser == FN_SAMPLE)
                    expected_out.push_back(filter_sample(int'(beat.sample_in)));
                else if (beat.coef_index < COEFS_PER_SEC && beat.coef_section < MAX_SEC)
                    coef_tbl[beat.coef_section][beat.coef_index] = int'(beat.coef_value);
                // out-of-range selectors leave the table alone
            end
        end
        errors  <= err_count;
        pending <= expected_out.size();
        checked <= n_checked;
    end

endmodule

[tb/cascaded_biquad_iir_filter_unit_test.sv]
// Top of the biquad cascade test: clock, reset, coefficient/sample stimulus and
// section-count phases, with bqd_cascade_checker scoring the output stream.
// Depends on bqd_pkg, bqd_tb_pkg and the cascaded_biquad_iir_filter_unit RTL.
module cascaded_biquad_iir_filter_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bqd_pkg::*;
    import bqd_tb_pkg::*;

    localparam int SETTLE_CYCLES = 7 * MAX_SEC + 12;   // longer than one full sample
    localparam int N_PHASES      = 12;
    localparam int PHASE_ITEMS   = 119;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [NSEC_W-1:0]    cfg_wdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [TDATA_W-1:0]   s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [31:0]          m_axis_tdata;

    int   errors;
    int   pending;
    int   checked;
    logic steady;
    int   n_samples;
    int   n_coefs;
    int   n_settings;

    cascaded_biquad_iir_filter_unit #(
        .MAX_SECTIONS(MAX_SEC)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    bqd_cascade_checker cascade_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .errors   (errors),
        .pending  (pending),
        .checked  (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(10_000_000);
        $display("simulation failed");
        $finish;
    end

    // output side backpressure
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            m_axis_tready <= steady || ($urandom_range(99) >= 6);
        end
    end

    function automatic int pick_word();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 0;
            3:       return -1;
            4, 5:    return int'($urandom_range(2047)) - 1024;
            default: return int'($urandom);
        endcase
    endfunction

    task automatic push_beat(input func_t fn, input logic [CSEC_W-1:0] sec,
                             input logic [CIDX_W-1:0] idx, input int cval, input int x);
        beat_t b;
        b = '{pad: '0, sample_in: x, coef_value: cval, coef_index: idx, coef_section: sec};
        if (!steady && $urandom_range(99) < 6)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= fn;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (fn == FN_SAMPLE)
            n_samples++;
        else
            n_coefs++;
    endtask

    // stop sending and wait for every outstanding sample to come back
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic set_sections(input logic [NSEC_W-1:0] n);
        settle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= n;
        @(posedge clk);
        cfg_we    <= 1'b0;
        n_settings++;
    endtask

    initial
    begin
        int                sent;
        int                roll;
        bit                held;
        logic [CSEC_W-1:0] sec;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FN_COEF;
        steady        = 1'b0;
        n_samples     = 0;
        n_coefs       = 0;
        n_settings    = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // cleared table: output must be zero even at full-scale input
        push_beat(FN_SAMPLE, 3'd0, 3'd0, 0, 32'h7FFF_FFFF);
        push_beat(FN_SAMPLE, 3'd7, 3'd7, -1, 32'h8000_0000);
        push_beat(FN_COEF, 3'd0, CI_A1, 32'h0800_0000, 0);
        push_beat(FN_COEF, 3'd0, CI_A2, 32'hFC00_0000, 0);
        push_beat(FN_COEF, 3'd0, CI_B0, 32'h7FFF_FFFF, 0);
        push_beat(FN_COEF, 3'd0, CI_B1, 32'h8000_0000, 0);
        push_beat(FN_COEF, 3'd0, CI_B2, 32'h2000_0000, 0);
        // selectors past b2 must not land anywhere
        push_beat(FN_COEF, 3'd0, 3'd5, 32'h5555_5555, 0);
        push_beat(FN_COEF, 3'd0, 3'd7, 32'hAAAA_AAAA, 0);
        push_beat(FN_COEF, 3'd7, CI_B0, 32'h4000_0000, 0);
        push_beat(FN_SAMPLE, 3'd0, 3'd0, 0, 32'h7FFF_FFFF);
        push_beat(FN_SAMPLE, 3'd0, 3'd0, 0, 32'h8000_0000);
        push_beat(FN_SAMPLE, 3'd0, 3'd0, 0, 0);
        push_beat(FN_SAMPLE, 3'd0, 3'd0, 0, -1);
        push_beat(FN_SAMPLE, 3'd0, 3'd0, 0, 1);
        push_beat(FN_SAMPLE, 3'd0, 3'd0, 0, 32'h1234_5678);
        // section count above the table size clamps to the full cascade
        set_sections(4'd15);
        push_beat(FN_SAMPLE, 3'd0, 3'd0, 0, 32'h7FFF_FFFF);
        push_beat(FN_SAMPLE, 3'd0, 3'd0, 0, 32'h8000_0000);
        push_beat(FN_SAMPLE, 3'd0, 3'd0, 0, 100);
        // zero sections behaves as one
        set_sections(4'd0);
        push_beat(FN_SAMPLE, 3'd0, 3'd0, 0, 1);
        set_sections(4'd8);
        push_beat(FN_SAMPLE, 3'd0, 3'd0, 0, -2);

        held = 1'b0;
        for (int p = 0; p < N_PHASES; p++)
        begin
            case (p)
                0:       set_sections(4'd8);
                1:       set_sections(4'd1);
                2:       set_sections(4'd15);
                3:       set_sections(4'd0);
                default: set_sections(NSEC_W'($urandom_range(15)));
            endcase
            steady = (p == 6);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if (p == 4 && !held && sent >= PHASE_ITEMS / 2)
                begin
                    settle();
                    held = 1'b1;
                end
                roll = $urandom_range(99);
                if (roll < 8)
                begin
                    // full coefficient set for one section, a1 through b2
                    sec = CSEC_W'($urandom_range(7));
                    for (int k = 0; k < COEFS_PER_SEC; k++)
                        push_beat(FN_COEF, sec, CIDX_W'(k), pick_word(), int'($urandom));
                    sent += COEFS_PER_SEC;
                end
                else if (roll < 13)
                begin
                    push_beat(FN_COEF, CSEC_W'($urandom_range(7)), CIDX_W'($urandom_range(7)),
                              pick_word(), int'($urandom));
                    sent++;
                end
                else
                begin
                    push_beat(FN_SAMPLE, CSEC_W'($urandom), CIDX_W'($urandom),
                              int'($urandom), pick_word());
                    sent++;
                end
            end
        end

        settle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("sent %0d samples and %0d coefficient beats across %0d section-count settings",
                 n_samples, n_coefs, n_settings);
        $display("%0d filtered outputs compared against the predicted cascade", checked);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
